@@ hdl/tlssni_pkg.sv @@
package tlssni_pkg;

  // record header (type, version, length) + handshake header and version + random
  localparam logic [15:0] HDR_SKIP       = 16'((1 + 2 + 2) + (1 + 3 + 2) + 32);
  localparam logic [15:0] SNI_EXT_TYPE   = 16'h0000;
  localparam logic [7:0]  HOST_NAME_TYPE = 8'h00;
  // extension length and server name list length, skipped unchecked
  localparam logic [15:0] SNI_INNER_SKIP = 16'd4;

  typedef enum logic [4:0] {
    PH_HDR     = 5'd0,
    PH_SID_LEN = 5'd1,
    PH_SID_SKIP= 5'd2,
    PH_CS_HI   = 5'd3,
    PH_CS_LO   = 5'd4,
    PH_CS_SKIP = 5'd5,
    PH_CM_LEN  = 5'd6,
    PH_CM_SKIP = 5'd7,
    PH_EXTS_HI = 5'd8,
    PH_EXTS_LO = 5'd9,
    PH_TYPE_HI = 5'd10,
    PH_TYPE_LO = 5'd11,
    PH_ELEN_HI = 5'd12,
    PH_ELEN_LO = 5'd13,
    PH_EBODY   = 5'd14,
    PH_SN_SKIP = 5'd15,
    PH_SN_TYPE = 5'd16,
    PH_NLEN_HI = 5'd17,
    PH_NLEN_LO = 5'd18,
    PH_NAME    = 5'd19,
    PH_DONE    = 5'd20
  } phase_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       byte_valid;
    logic       name_done;
    logic       found;
  } res_t;

endpackage

@@ hdl/tlssni_parser.sv @@
module tlssni_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [7:0]        data_byte,
  input  logic              end_of_record,
  output logic              res_valid,
  output tlssni_pkg::res_t  res
);
  import tlssni_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] skip_count, skip_count_next;
  logic [7:0]  length_high_byte, length_high_byte_next;
  logic [15:0] ext_left, ext_left_next;
  logic [15:0] name_left, name_left_next;
  logic        result_given, result_given_next;

  logic [15:0] len16;
  logic [15:0] skip_dec;
  logic [15:0] ext_dec;
  logic [15:0] name_dec;
  logic        name_fin;
  logic        miss;
  logic        step_res;

  assign len16    = {length_high_byte, data_byte};
  assign skip_dec = skip_count - 16'd1;
  assign ext_dec  = (ext_left != 16'd0) ? ext_left - 16'd1 : ext_left;
  assign name_dec = name_left - 16'd1;
  assign name_fin = (name_dec == 16'd0) || end_of_record;

  // parse failure: emit not-found and stop
  always_comb begin
    case (phase)
      PH_EXTS_LO: miss = (len16 == 16'd0);
      PH_ELEN_LO: miss = (len16 == 16'd0) && (ext_dec == 16'd0);
      PH_EBODY:   miss = (skip_dec == 16'd0) && (ext_dec == 16'd0);
      PH_SN_TYPE: miss = (data_byte != HOST_NAME_TYPE);
      default:    miss = 1'b0;
    endcase
  end

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HDR:      if (skip_dec == 16'd0) phase_next = PH_SID_LEN;
      PH_SID_SKIP: if (skip_dec == 16'd0) phase_next = PH_CS_HI;
      PH_CS_SKIP:  if (skip_dec == 16'd0) phase_next = PH_CM_LEN;
      PH_CM_SKIP:  if (skip_dec == 16'd0) phase_next = PH_EXTS_HI;
      PH_SN_SKIP:  if (skip_dec == 16'd0) phase_next = PH_SN_TYPE;
      PH_SID_LEN:  phase_next = (data_byte != 8'd0) ? PH_SID_SKIP : PH_CS_HI;
      PH_CS_HI:    phase_next = PH_CS_LO;
      PH_CS_LO:    phase_next = (len16 != 16'd0) ? PH_CS_SKIP : PH_CM_LEN;
      PH_CM_LEN:   phase_next = (data_byte != 8'd0) ? PH_CM_SKIP : PH_EXTS_HI;
      PH_EXTS_HI:  phase_next = PH_EXTS_LO;
      PH_EXTS_LO:  phase_next = PH_TYPE_HI;
      PH_TYPE_HI:  phase_next = PH_TYPE_LO;
      PH_TYPE_LO:  phase_next = (len16 == SNI_EXT_TYPE) ? PH_SN_SKIP : PH_ELEN_HI;
      PH_ELEN_HI:  phase_next = PH_ELEN_LO;
      PH_ELEN_LO:  phase_next = (len16 != 16'd0) ? PH_EBODY : PH_TYPE_HI;
      PH_EBODY:    if (skip_dec == 16'd0) phase_next = PH_TYPE_HI;
      PH_SN_TYPE:  phase_next = PH_NLEN_HI;
      PH_NLEN_HI:  phase_next = PH_NLEN_LO;
      PH_NLEN_LO:  phase_next = (len16 == 16'd0) ? PH_DONE : PH_NAME;
      PH_NAME:     if (name_fin) phase_next = PH_DONE;
      default:     phase_next = PH_DONE;
    endcase
    if (miss) phase_next = PH_DONE;
    if (end_of_record) phase_next = PH_HDR;
  end

  // counters and length capture
  always_comb begin
    skip_count_next       = skip_count;
    length_high_byte_next = length_high_byte;
    ext_left_next         = ext_left;
    name_left_next        = name_left;
    case (phase)
      PH_HDR, PH_SID_SKIP, PH_CS_SKIP, PH_CM_SKIP, PH_SN_SKIP:
        skip_count_next = skip_dec;
      PH_SID_LEN, PH_CM_LEN:
        skip_count_next = {8'd0, data_byte};
      PH_CS_HI, PH_EXTS_HI, PH_NLEN_HI:
        length_high_byte_next = data_byte;
      PH_CS_LO:
        skip_count_next = len16;
      PH_EXTS_LO:
        ext_left_next = len16;
      PH_TYPE_HI, PH_ELEN_HI: begin
        ext_left_next         = ext_dec;
        length_high_byte_next = data_byte;
      end
      PH_TYPE_LO: begin
        ext_left_next = ext_dec;
        if (len16 == SNI_EXT_TYPE) skip_count_next = SNI_INNER_SKIP;
      end
      PH_ELEN_LO: begin
        ext_left_next = ext_dec;
        if (len16 != 16'd0) skip_count_next = len16;
      end
      PH_EBODY: begin
        ext_left_next   = ext_dec;
        skip_count_next = skip_dec;
      end
      PH_NLEN_LO:
        name_left_next = len16;
      PH_NAME:
        name_left_next = name_dec;
      default: ;
    endcase
    if (end_of_record) begin
      skip_count_next       = HDR_SKIP;
      length_high_byte_next = 8'd0;
      ext_left_next         = 16'd0;
      name_left_next        = 16'd0;
    end
  end

  // result for this byte
  always_comb begin
    step_res = 1'b0;
    res      = '0;
    if (phase == PH_NLEN_LO && len16 == 16'd0) begin
      step_res      = 1'b1;
      res.name_done = 1'b1;
      res.found     = 1'b1;
    end else if (phase == PH_NAME) begin
      step_res       = 1'b1;
      res.name_byte  = data_byte;
      res.byte_valid = 1'b1;
      res.name_done  = name_fin;
      res.found      = 1'b1;
    end
    if (miss) begin
      step_res = 1'b1;
      res      = '0;
      res.name_done = 1'b1;
    end
    // record ended with nothing reported yet
    if (end_of_record && !step_res && !result_given) begin
      step_res      = 1'b1;
      res.name_done = 1'b1;
    end
    res_valid = in_fire && step_res;
  end

  always_comb begin
    result_given_next = result_given;
    if (step_res && res.name_done) result_given_next = 1'b1;
    if (end_of_record) result_given_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HDR;
      skip_count       <= HDR_SKIP;
      length_high_byte <= 8'd0;
      ext_left         <= 16'd0;
      name_left        <= 16'd0;
      result_given     <= 1'b0;
    end else if (in_fire) begin
      phase            <= phase_next;
      skip_count       <= skip_count_next;
      length_high_byte <= length_high_byte_next;
      ext_left         <= ext_left_next;
      name_left        <= name_left_next;
      result_given     <= result_given_next;
    end
  end

endmodule

@@ hdl/tlssni_out_buf.sv @@
module tlssni_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tlssni_pkg::res_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output tlssni_pkg::res_t  out_data
);
  import tlssni_pkg::*;

  res_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/tls_client_hello_sni_extract.sv @@
// TLS ClientHello server-name extractor.
// Slave channel: one record byte per transfer on s_tdata, s_tlast on the final
// byte of the record. Master channel: zero or one result per input byte, the
// name byte on m_tdata, m_tlast marking the last result of the record, and
// m_tuser carrying the byte-valid and found flags.
// Each byte updates the parse state in the cycle of its transfer; a result
// is registered in the output buffer before it appears on the master side.
// Throughput is one byte per cycle while s_tready is high: the only loop is
// the phase and counter update.
// Results wait in a two-entry output buffer, so bytes keep flowing while a
// result is held. If the receiver stalls and both entries fill, s_tready
// drops until a result is taken; nothing is lost or reordered.
// A record with no host-name entry gives one not-found result (m_tlast high,
// both flags low); a host name cut by the end of the record ends on its last
// received byte. After the final byte the parser starts on the next record.
// Reset (rst, synchronous) returns to the header skip and empties the buffer.
module tls_client_hello_sni_extract (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_record
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] name_byte
  output logic [1:0] m_tuser,   // [0] byte_valid, [1] found
  output logic       m_tlast    // name_done
);
  import tlssni_pkg::*;

  logic in_fire;
  logic res_valid;
  res_t res;
  res_t out_res;
  logic buf_full;

  assign s_tready = !buf_full;
  assign in_fire  = s_tvalid && s_tready;

  tlssni_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .data_byte     (s_tdata),
    .end_of_record (s_tlast),
    .res_valid     (res_valid),
    .res           (res)
  );

  tlssni_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = out_res.name_byte;
  assign m_tuser = {out_res.found, out_res.byte_valid};
  assign m_tlast = out_res.name_done;

endmodule
